// ===== rtl/core/sawlc_pkg.sv =====
// ----------------------------------------------------------------------------
// sawlc_pkg
// Shared types and constants of the set-associative write-back LRU cache.
// ----------------------------------------------------------------------------
package sawlc_pkg;

   localparam int DEF_NUM_SETS         = 64;
   localparam int DEF_WAYS             = 4;
   localparam int DEF_BLOCK_BYTES      = 16;
   localparam int DEF_ADDR_BITS        = 16;
   localparam int DEF_MAX_ACCESS_BYTES = 8;

   localparam logic [7:0] FILL_BYTE = 8'h30;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] address;
      logic [3:0]  access_bytes;
      logic [63:0] store_data;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] load_data;
      logic        crosses_block;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic look;
      logic wb;
      logic fill;
      logic acc;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic crosses;
      logic hit;
      logic victim_dirty;
   } sts_type;

endpackage

// ===== rtl/core/sawlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sawlc_ctrl
// Sequencer of the cache: memory clearing pass, lookup, write-back, fill,
// access and result hand-off.
// ----------------------------------------------------------------------------
module sawlc_ctrl
   import sawlc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_WB    = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.accept   = accept;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            if (sts.crosses)           state_in = S_RESP;
            else if (sts.hit)          state_in = S_ACC;
            else if (sts.victim_dirty) state_in = S_WB;
            else                       state_in = S_FILL;
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOOK) else $error("accepted item did not start lookup");
   a_wb_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WB |=> state_ff == S_FILL) else $error("write-back not followed by fill");
   a_acc_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACC |=> state_ff == S_RESP) else $error("access not followed by result");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_valid_ff && rsp_stall) |=> state_ff == S_RESP)
      else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/sawlc_dpath.sv =====
// ----------------------------------------------------------------------------
// sawlc_dpath
// Datapath of the cache: metadata, line data and backing memories, lookup,
// victim choice, LRU update, byte merge and result register.
// ----------------------------------------------------------------------------
module sawlc_dpath
   import sawlc_pkg::*;
#(
   parameter int NUM_SETS         = DEF_NUM_SETS,
   parameter int WAYS             = DEF_WAYS,
   parameter int BLOCK_BYTES      = DEF_BLOCK_BYTES,
   parameter int ADDR_BITS        = DEF_ADDR_BITS,
   parameter int MAX_ACCESS_BYTES = DEF_MAX_ACCESS_BYTES
)
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   output rsp_type rsp_data,
   input  cmd_type cmd,
   output sts_type sts
);

   localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
   localparam int SET_BITS   = $clog2(NUM_SETS);
   localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;
   localparam int TAG_W      = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINES      = NUM_SETS * WAYS;
   localparam int LINE_W     = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int ROW_W      = ADDR_BITS - OFF_BITS;
   localparam int MEM_ROWS   = 2 ** ROW_W;
   localparam int BLOCK_BITS = BLOCK_BYTES * 8;
   localparam int ENTRY_W    = TAG_W + 2 + WAY_W;
   localparam int META_W     = WAYS * ENTRY_W;
   localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

   logic [META_W-1:0]     meta_mem [NUM_SETS];
   logic [BLOCK_BITS-1:0] cache_mem [LINES];
   logic [BLOCK_BITS-1:0] back_mem [MEM_ROWS];

   logic [NUM_SETS-1:0]   live_ff;
   logic                  live_rd_ff;
   logic [META_W-1:0]     meta_ff;
   logic [BLOCK_BITS-1:0] line_ff;
   logic [BLOCK_BITS-1:0] mem_rd_ff;
   logic [ROW_W-1:0]      clr_ff;

   logic                  op_ff;
   logic [OFF_BITS-1:0]   off_ff;
   logic [SET_W-1:0]      set_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [3:0]            n_ff;
   logic [63:0]           sdata_ff;
   logic                  cross_ff;
   logic                  hit_ff;
   logic [WAY_W-1:0]      way_ff;
   logic [TAG_W-1:0]      vtag_ff;
   logic [63:0]           load_ff;
   rsp_type               rsp_ff;

   logic [31:0]           addr32;
   logic [OFF_BITS-1:0]   off_in;
   logic [3:0]            n_in;
   logic                  cross_in;

   logic [TAG_W-1:0]      tag_a   [WAYS];
   logic                  val_a   [WAYS];
   logic                  dirty_a [WAYS];
   logic [WAY_W-1:0]      rank_a  [WAYS];
   logic                  hit_c;
   logic [WAY_W-1:0]      hit_way;
   logic                  inv_found;
   logic [WAY_W-1:0]      inv_way;
   logic [WAY_W-1:0]      lru_way;
   logic [WAY_W-1:0]      way_sel;
   logic [LINE_W-1:0]     look_line;
   logic [LINE_W-1:0]     cur_line;
   logic [ROW_W-1:0]      vrow;
   logic [WAY_W-1:0]      old_rank;
   logic [META_W-1:0]     meta_new;

   logic [BLOCK_BITS-1:0] shifted;
   logic [BLOCK_BITS-1:0] sd_wide;
   logic [BLOCK_BITS-1:0] merged;
   logic [63:0]           load_c;

   always_comb begin
      addr32   = 32'(req_data.address) & ADDR_MASK;
      off_in   = OFF_BITS'(addr32);
      n_in     = (32'(req_data.access_bytes) > MAX_ACCESS_BYTES) ?
                 4'(MAX_ACCESS_BYTES) : req_data.access_bytes;
      cross_in = (32'(off_in) + 32'(n_in)) > BLOCK_BYTES;
   end

   always_comb begin
      hit_c     = 1'b0;
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      lru_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         tag_a[w]   = meta_ff[w*ENTRY_W + WAY_W + 2 +: TAG_W];
         val_a[w]   = live_rd_ff && meta_ff[w*ENTRY_W + WAY_W + 1];
         dirty_a[w] = live_rd_ff && meta_ff[w*ENTRY_W + WAY_W];
         rank_a[w]  = live_rd_ff ? meta_ff[w*ENTRY_W +: WAY_W] : WAY_W'(w);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (val_a[w] && tag_a[w] == tag_ff) begin
            hit_c   = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!val_a[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
         if (32'(rank_a[w]) == WAYS - 1) lru_way = WAY_W'(w);
      end
      way_sel   = hit_c ? hit_way : (inv_found ? inv_way : lru_way);
      look_line = LINE_W'(32'(set_ff) * WAYS + 32'(way_sel));
      cur_line  = LINE_W'(32'(set_ff) * WAYS + 32'(way_ff));
      vrow      = ROW_W'((32'(vtag_ff) << SET_BITS) | 32'(set_ff));
   end

   always_comb begin
      old_rank = rank_a[way_ff];
      meta_new = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == way_ff) begin
            meta_new[w*ENTRY_W + WAY_W + 2 +: TAG_W] = tag_ff;
            meta_new[w*ENTRY_W + WAY_W + 1]          = 1'b1;
            meta_new[w*ENTRY_W + WAY_W]              = hit_ff ?
                                                       (dirty_a[w] | op_ff) : op_ff;
            meta_new[w*ENTRY_W +: WAY_W]             = '0;
         end else begin
            meta_new[w*ENTRY_W + WAY_W + 2 +: TAG_W] = tag_a[w];
            meta_new[w*ENTRY_W + WAY_W + 1]          = val_a[w];
            meta_new[w*ENTRY_W + WAY_W]              = dirty_a[w];
            meta_new[w*ENTRY_W +: WAY_W]             = (rank_a[w] < old_rank) ?
                                                       rank_a[w] + 1'b1 : rank_a[w];
         end
      end
   end

   always_comb begin
      shifted = line_ff >> {off_ff, 3'b000};
      sd_wide = BLOCK_BITS'(sdata_ff) << {off_ff, 3'b000};
      load_c  = shifted[63:0];
      for (int b = 0; b < 8; b++) begin
         if (b >= 32'(n_ff)) load_c[b*8 +: 8] = 8'h00;
      end
      merged = line_ff;
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         if (b >= 32'(off_ff) && b < 32'(off_ff) + 32'(n_ff))
            merged[b*8 +: 8] = sd_wide[b*8 +: 8];
      end
   end

   assign sts.clear_last   = (clr_ff == {ROW_W{1'b1}});
   assign sts.crosses      = cross_ff;
   assign sts.hit          = hit_c;
   assign sts.victim_dirty = val_a[way_sel] && dirty_a[way_sel];
   assign rsp_data         = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         clr_ff  <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.acc)   live_ff[set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         meta_ff    <= meta_mem[SET_W'((addr32 >> OFF_BITS) & (NUM_SETS - 1))];
         live_rd_ff <= live_ff[SET_W'((addr32 >> OFF_BITS) & (NUM_SETS - 1))];
      end
      if (cmd.acc) meta_mem[set_ff] <= meta_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.look) line_ff <= cache_mem[look_line];
      else if (cmd.fill) line_ff <= mem_rd_ff;
      if (cmd.fill) cache_mem[cur_line] <= mem_rd_ff;
      else if (cmd.acc && op_ff == OP_STORE) cache_mem[cur_line] <= merged;
   end

   always_ff @(posedge clock) begin
      if (cmd.look) mem_rd_ff <= back_mem[row_ff];
      if (cmd.clear) back_mem[clr_ff] <= {BLOCK_BYTES{FILL_BYTE}};
      else if (cmd.wb) back_mem[vrow] <= line_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_data.op;
         off_ff   <= off_in;
         set_ff   <= SET_W'((addr32 >> OFF_BITS) & (NUM_SETS - 1));
         tag_ff   <= TAG_W'(addr32 >> (OFF_BITS + SET_BITS));
         row_ff   <= ROW_W'(addr32 >> OFF_BITS);
         n_ff     <= n_in;
         sdata_ff <= req_data.store_data;
         cross_ff <= cross_in;
      end
      if (cmd.look) begin
         hit_ff  <= hit_c;
         way_ff  <= way_sel;
         vtag_ff <= tag_a[way_sel];
      end
      if (cmd.acc) load_ff <= (op_ff == OP_STORE) ? 64'd0 : load_c;
      if (cmd.rsp_load) begin
         rsp_ff.hit           <= cross_ff ? 1'b0 : hit_ff;
         rsp_ff.load_data     <= cross_ff ? 64'd0 : load_ff;
         rsp_ff.crosses_block <= cross_ff;
      end
   end

endmodule

// ===== rtl/core/set_assoc_writeback_lru_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// Set-associative write-allocate, write-back cache with true LRU in front of
// a byte memory held inside the block.
//
// Input channel req_*: one load or store of up to eight bytes per item.
// Result channel rsp_*: one result per item, in order: hit flag, loaded
// bytes and a flag for an access that runs past the block end.
// Both channels move an item on a clock edge with valid high and stall low.
// One item is in work at a time. From acceptance to result valid, a hit
// passes the lookup, access and result steps; a clean miss adds a fill
// from one backing row read; a dirty miss also writes the victim back to
// its row before the fill; an access that crosses a block end goes from
// lookup straight to result. The next item can be accepted after its
// result is loaded. Each block moves as one memory row.
// After reset the backing memory is swept to 0x30, one block row per cycle,
// 2**ADDR_BITS / BLOCK_BYTES rows (4096 by default); req_stall is high
// during the sweep. A result waits in the output register while rsp_stall
// is high; the next item may be accepted meanwhile, but holds in its result
// step until the waiting result is taken.
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache
   import sawlc_pkg::*;
#(
   parameter int NUM_SETS         = DEF_NUM_SETS,
   parameter int WAYS             = DEF_WAYS,
   parameter int BLOCK_BYTES      = DEF_BLOCK_BYTES,
   parameter int ADDR_BITS        = DEF_ADDR_BITS,
   parameter int MAX_ACCESS_BYTES = DEF_MAX_ACCESS_BYTES
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   sawlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   sawlc_dpath #(
      .NUM_SETS         (NUM_SETS),
      .WAYS             (WAYS),
      .BLOCK_BYTES      (BLOCK_BYTES),
      .ADDR_BITS        (ADDR_BITS),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative write-back LRU cache. A driver
// feeds random and directed loads and stores; a behavioral cache with its own
// LRU ranks and backing memory predicts every result; a monitor compares.
// ----------------------------------------------------------------------------
module tb;
   import sawlc_pkg::*;

   localparam int NSETS = DEF_NUM_SETS;
   localparam int NWAYS = DEF_WAYS;
   localparam int BLK   = DEF_BLOCK_BYTES;
   localparam int MEMSZ = 1 << DEF_ADDR_BITS;
   localparam int LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   set_assoc_writeback_lru_cache dut (.*);

   always #2 clock = ~clock;

   logic [5:0] line_tag   [NSETS*NWAYS];
   logic       line_valid [NSETS*NWAYS];
   logic       line_dirty [NSETS*NWAYS];
   int         line_rank  [NSETS*NWAYS];
   logic [7:0] line_bytes [NSETS*NWAYS*BLK];
   logic [7:0] mem_model  [MEMSZ];

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   bit      hold_for_drain = 1'b0;
   bit      stim_done = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic rsp_type cache_access(req_type it);
      rsp_type    r;
      int         n, off, set, tag, way, ln, base, wb, old;
      bit         found;
      r = '0;
      n = (it.access_bytes > 8) ? 8 : it.access_bytes;
      off = it.address % BLK;
      set = (it.address / BLK) % NSETS;
      tag = it.address / (BLK * NSETS);
      if (off + n > BLK) begin
         r.crosses_block = 1'b1;
         return r;
      end
      found = 1'b0;
      way = 0;
      for (int w = 0; w < NWAYS; w++) begin
         if (!found && line_valid[set*NWAYS+w] && line_tag[set*NWAYS+w] == tag) begin
            found = 1'b1;
            way = w;
         end
      end
      if (!found) begin
         way = -1;
         for (int w = 0; w < NWAYS; w++)
            if (way < 0 && !line_valid[set*NWAYS+w]) way = w;
         if (way < 0) begin
            way = 0;
            for (int w = 0; w < NWAYS; w++)
               if (line_rank[set*NWAYS+w] > line_rank[set*NWAYS+way]) way = w;
         end
         ln = set*NWAYS + way;
         if (line_valid[ln] && line_dirty[ln]) begin
            wb = (line_tag[ln] * NSETS + set) * BLK;
            for (int i = 0; i < BLK; i++) mem_model[(wb+i) % MEMSZ] = line_bytes[ln*BLK+i];
         end
         base = it.address - off;
         for (int i = 0; i < BLK; i++) line_bytes[ln*BLK+i] = mem_model[base+i];
         line_tag[ln] = tag[5:0];
         line_valid[ln] = 1'b1;
         line_dirty[ln] = 1'b0;
      end
      ln = set*NWAYS + way;
      old = line_rank[ln];
      for (int w = 0; w < NWAYS; w++)
         if (line_rank[set*NWAYS+w] < old) line_rank[set*NWAYS+w]++;
      line_rank[ln] = 0;
      if (it.op == OP_STORE) begin
         for (int i = 0; i < n; i++) line_bytes[ln*BLK+off+i] = it.store_data[8*i +: 8];
         line_dirty[ln] = 1'b1;
      end else begin
         for (int i = 0; i < n; i++) r.load_data[8*i +: 8] = line_bytes[ln*BLK+off+i];
      end
      r.hit = found;
      return r;
   endfunction

   function automatic req_type make_item(logic op, logic [15:0] a, logic [3:0] n,
                                         logic [63:0] d);
      req_type it;
      it.op = op;
      it.address = a;
      it.access_bytes = n;
      it.store_data = d;
      return it;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // hold
      end else begin
         if (req_valid) begin
            expected_rsps.push_back(cache_access(req_data));
            send_gap = pick_gap();
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (hold_for_drain && (expected_rsps.size() != 0 || req_valid)) begin
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            hold_for_drain = 1'b0;
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (!req_valid) stim_done = 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected item: %p", $time, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.hit !== rsp_data.hit)
                  $display("%0t hit: exp %0h got %0h", $time, e.hit, rsp_data.hit);
               if (e.load_data !== rsp_data.load_data)
                  $display("%0t load_data: exp %h got %h", $time, e.load_data,
                           rsp_data.load_data);
               if (e.crosses_block !== rsp_data.crosses_block)
                  $display("%0t crosses_block: exp %0h got %0h", $time, e.crosses_block,
                           rsp_data.crosses_block);
               if (e !== rsp_data) errors++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall && $urandom_range(0, 3) == 0) begin
            recv_gap = pick_gap();
            rsp_stall <= (recv_gap > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int cnt;
      logic [15:0] hot [8];
      logic [15:0] a;
      for (int i = 0; i < NSETS*NWAYS; i++) begin
         line_tag[i] = '0;
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_rank[i] = i % NWAYS;
      end
      for (int i = 0; i < NSETS*NWAYS*BLK; i++) line_bytes[i] = '0;
      for (int i = 0; i < MEMSZ; i++) mem_model[i] = FILL_BYTE;

      // directed: extremes, zero and oversized length, crossings, evictions
      pending_items.push_back(make_item(OP_LOAD, 16'h0000, 4'd8, '0));
      pending_items.push_back(make_item(OP_STORE, 16'h0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      pending_items.push_back(make_item(OP_LOAD, 16'h0000, 4'd15, '0));
      pending_items.push_back(make_item(OP_STORE, 16'hFFF8, 4'd8, 64'h0123_4567_89AB_CDEF));
      pending_items.push_back(make_item(OP_LOAD, 16'hFFF8, 4'd8, '0));
      pending_items.push_back(make_item(OP_LOAD, 16'hFFFF, 4'd1, '0));
      pending_items.push_back(make_item(OP_LOAD, 16'hFFFF, 4'd2, '0));
      pending_items.push_back(make_item(OP_STORE, 16'h0009, 4'd8, 64'h5555_5555_5555_5555));
      pending_items.push_back(make_item(OP_STORE, 16'h0010, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA));
      pending_items.push_back(make_item(OP_LOAD, 16'h0020, 4'd0, '0));
      for (int k = 1; k <= 5; k++)
         pending_items.push_back(make_item(OP_STORE, 16'(k * 1024 + 3), 4'd4, rand64()));
      pending_items.push_back(make_item(OP_LOAD, 16'h0003, 4'd4, '0));
      pending_items.push_back(make_item(OP_LOAD, 16'h0403, 4'd4, '0));
      pending_items.push_back(make_item(OP_LOAD, 16'h0008, 4'd8, '0));
      pending_items.push_back(make_item(OP_STORE, 16'h7FF0, 4'd15, 64'h8000_0000_0000_0001));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 8; i++) hot[i] = 16'($urandom);
      cnt = 0;
      while (cnt < 1050) begin
         if (cnt == 500) begin
            wait (pending_items.size() == 0);
            @(posedge clock);
            hold_for_drain = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1:    a = 16'($urandom);
            2, 3, 4: a = {$urandom_range(0, 15) % 8 == 0 ? 6'($urandom) : 6'($urandom_range(0, 5)),
                          4'($urandom_range(0, 1)), 6'($urandom)};
            default: a = hot[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 15));
         endcase
         if ($urandom_range(0, 15) == 0) hot[$urandom_range(0, 7)] = 16'($urandom);
         pending_items.push_back(make_item(1'($urandom), a,
                                 ($urandom_range(0, 19) == 0) ? 4'($urandom)
                                                              : 4'($urandom_range(1, 8)),
                                 rand64()));
         cnt++;
      end

      wait (stim_done && expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
